FILE: src/four_bit_microcontroller_core_assert.svh
// Assertion macros used by the port-level checker of the four-bit core.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef FOUR_BIT_MICROCONTROLLER_CORE_ASSERT_SVH
`define FOUR_BIT_MICROCONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define FBMC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define FBMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/fbmc_pkg.sv
// Package of the four-bit microcontroller core: types, opcodes, tables.
// No dependencies; used by fbmc_ram, fbmc_exec and the core top level.
`default_nettype none

package fbmc_pkg;

  // Opcode group codes
  localparam logic [1:0] GrpBr   = 2'b10;
  localparam logic [1:0] GrpCall = 2'b11;

  localparam logic [3:0] GrpLdp  = 4'h1;
  localparam logic [3:0] GrpTcy  = 4'h4;
  localparam logic [3:0] GrpYnec = 4'h5;
  localparam logic [3:0] GrpTcmiy = 4'h6;
  localparam logic [3:0] GrpAlec = 4'h7;

  localparam logic [5:0] GrpSbit = 6'b0011_00;
  localparam logic [5:0] GrpRbit = 6'b0011_01;
  localparam logic [5:0] GrpTbit = 6'b0011_10;
  localparam logic [5:0] GrpLdx  = 6'b0011_11;

  typedef enum logic [7:0] {
    OP_COMX   = 8'h00, OP_A8AAC  = 8'h01, OP_YNEA  = 8'h02, OP_TAM   = 8'h03,
    OP_TAMZA  = 8'h04, OP_A10AAC = 8'h05, OP_A6AAC = 8'h06, OP_DAN   = 8'h07,
    OP_TKA    = 8'h08, OP_KNEZ   = 8'h09, OP_TDO   = 8'h0a, OP_CLO   = 8'h0b,
    OP_RSTR   = 8'h0c, OP_SETR   = 8'h0d, OP_IA    = 8'h0e, OP_RETN  = 8'h0f,
    OP_TAMIY  = 8'h20, OP_TMA    = 8'h21, OP_TMY   = 8'h22, OP_TYA   = 8'h23,
    OP_TAY    = 8'h24, OP_AMAAC  = 8'h25, OP_MNEZ  = 8'h26, OP_SAMAN = 8'h27,
    OP_IMAC   = 8'h28, OP_ALEM   = 8'h29, OP_DMAN  = 8'h2a, OP_IYC   = 8'h2b,
    OP_DYN    = 8'h2c, OP_CPAIZ  = 8'h2d, OP_XMA   = 8'h2e, OP_CLA   = 8'h2f
  } fbmc_op_e;

  typedef struct packed {
    logic [5:0]  pc;
    logic [3:0]  page;
    logic [3:0]  pbuf;
    logic        cl;
    logic [5:0]  ret;
    logic        s;
    logic [3:0]  a;
    logic [1:0]  x;
    logic [3:0]  y;
    logic [6:0]  o;
    logic [15:0] r;
  } fbmc_state_t;

  localparam fbmc_state_t StateReset = '{
    pc: 6'h00, page: 4'hf, pbuf: 4'hf, cl: 1'b0, ret: 6'h00, s: 1'b0,
    a: 4'h0, x: 2'h0, y: 4'h0, o: 7'h00, r: 16'h0000
  };

  typedef struct packed {
    logic       we;
    logic [5:0] addr;
    logic [3:0] data;
  } fbmc_ram_wr_t;

  typedef struct packed {
    logic [9:0]  fetch_address;
    logic [6:0]  o_outputs;
    logic [15:0] r_outputs;
    logic        status_out;
    logic        illegal_opcode;
    logic [3:0]  acc_out;
  } fbmc_res_t;

  // Constants and bit numbers in opcodes are bit-reversed
  function automatic logic [3:0] rev4(input logic [3:0] v);
    return {v[0], v[1], v[2], v[3]};
  endfunction

  function automatic logic [1:0] rev2(input logic [1:0] v);
    return {v[0], v[1]};
  endfunction

  function automatic logic [6:0] seg7(input logic [3:0] v);
    logic [6:0] p;
    case (v)
      4'h0: p = 7'h7e;
      4'h1: p = 7'h30;
      4'h2: p = 7'h6d;
      4'h3: p = 7'h79;
      4'h4: p = 7'h33;
      4'h5: p = 7'h5b;
      4'h6: p = 7'h5f;
      4'h7: p = 7'h70;
      4'h8: p = 7'h7f;
      4'h9: p = 7'h7b;
      4'ha: p = 7'h77;
      4'hb: p = 7'h1f;
      4'hc: p = 7'h4e;
      4'hd: p = 7'h3d;
      4'he: p = 7'h4f;
      default: p = 7'h47;
    endcase
    return p;
  endfunction

  // LFSR program counter step; wraps 1f->3f and 3f->3e
  function automatic logic [5:0] next_pc(input logic [5:0] pc);
    logic fb;
    if (pc == 6'h1f) fb = 1'b1;
    else if (pc == 6'h3f) fb = 1'b0;
    else fb = ~(pc[5] ^ pc[4]);
    return {pc[4:0], fb};
  endfunction

endpackage

`default_nettype wire

FILE: src/fbmc_if.sv
// Valid/ready channel interfaces for instruction words and result words.
// No dependencies.
`default_nettype none

interface fbmc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] opcode;
  logic [3:0] key_pins;

  modport source (output valid, opcode, key_pins, input ready);
  modport sink (input valid, opcode, key_pins, output ready);
endinterface

interface fbmc_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  fetch_address;
  logic [6:0]  o_outputs;
  logic [15:0] r_outputs;
  logic        status_out;
  logic        illegal_opcode;
  logic [3:0]  acc_out;

  modport source (output valid, fetch_address, o_outputs, r_outputs, status_out,
                  illegal_opcode, acc_out, input ready);
  modport sink (input valid, fetch_address, o_outputs, r_outputs, status_out,
                illegal_opcode, acc_out, output ready);
endinterface

`default_nettype wire

FILE: src/fbmc_ram.sv
// 64 x 4 data RAM with registered read, per-entry valid bits and write bypass.
// Depends on fbmc_pkg.
`default_nettype none

module fbmc_ram import fbmc_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire fbmc_ram_wr_t wr_i,
  input  wire logic [5:0]   rd_addr_i,
  output logic [3:0]        rd_data_o
);

  logic [3:0]  mem_q [64];
  logic [3:0]  rd_raw_q;
  logic [3:0]  byp_data_q;
  logic [63:0] vld_q;
  logic        vld_rd_q;
  logic        byp_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_raw_q   <= mem_q[rd_addr_i];
    byp_data_q <= wr_i.data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      vld_rd_q <= 1'b0;
      byp_q    <= 1'b0;
    end else begin
      if (wr_i.we) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      vld_rd_q <= vld_q[rd_addr_i];
      byp_q    <= wr_i.we && (wr_i.addr == rd_addr_i);
    end
  end

  // never-written entries read as zero
  assign rd_data_o = byp_q ? byp_data_q : (vld_rd_q ? rd_raw_q : 4'h0);

endmodule

`default_nettype wire

FILE: src/fbmc_exec.sv
// Instruction decode and execute: next register state and RAM write.
// Depends on fbmc_pkg.
`default_nettype none

module fbmc_exec import fbmc_pkg::*; (
  input  wire fbmc_state_t  st_i,
  input  wire logic [7:0]   opcode_i,
  input  wire logic [3:0]   key_pins_i,
  input  wire logic [3:0]   mem_i,
  output fbmc_state_t       st_o,
  output fbmc_ram_wr_t      wr_o,
  output logic              illegal_o
);

  logic [3:0] c4;
  logic [3:0] bitm;
  logic [4:0] sum;
  logic       s;
  logic [3:0] a;
  logic [3:0] m;
  logic [3:0] y;

  always_comb begin
    st_o      = st_i;
    wr_o.we   = 1'b0;
    wr_o.addr = {st_i.x, st_i.y};
    wr_o.data = st_i.a;
    illegal_o = 1'b0;
    s         = 1'b1;
    a         = st_i.a;
    m         = mem_i;
    y         = st_i.y;
    c4        = rev4(opcode_i[3:0]);
    bitm      = 4'b0001 << rev2(opcode_i[1:0]);
    sum       = 5'h00;

    st_o.pc = next_pc(st_i.pc);

    case (opcode_i[7:6])
      GrpBr: begin
        if (st_i.s) begin
          if (!st_i.cl) st_o.page = st_i.pbuf;
          st_o.pc = opcode_i[5:0];
        end
      end
      GrpCall: begin
        if (st_i.s) begin
          st_o.page = st_i.pbuf;
          if (!st_i.cl) begin
            st_o.ret  = next_pc(st_i.pc);
            st_o.pbuf = st_i.page;
            st_o.cl   = 1'b1;
          end
          st_o.pc = opcode_i[5:0];
        end
      end
      default: begin
        case (opcode_i[7:4])
          GrpLdp:  st_o.pbuf = c4;
          GrpTcy:  st_o.y = c4;
          GrpYnec: s = (m != c4);
          GrpTcmiy: begin
            wr_o.we   = 1'b1;
            wr_o.data = c4;
            st_o.y    = y + 4'h1;
          end
          GrpAlec: s = (a <= c4);
          default: begin
            case (opcode_i[7:2])
              GrpSbit: begin
                wr_o.we   = 1'b1;
                wr_o.data = m | bitm;
              end
              GrpRbit: begin
                wr_o.we   = 1'b1;
                wr_o.data = m & ~bitm;
              end
              GrpTbit: s = |(m & bitm);
              GrpLdx:  st_o.x = rev2(opcode_i[1:0]);
              default: begin
                case (fbmc_op_e'(opcode_i))
                  OP_COMX: st_o.x = ~st_i.x;
                  OP_A8AAC: begin
                    sum = {1'b0, a} + 5'd8;
                    st_o.a = sum[3:0];
                    s = sum[4];
                  end
                  OP_YNEA: s = (y != a);
                  OP_TAM: wr_o.we = 1'b1;
                  OP_TAMZA: begin
                    wr_o.we = 1'b1;
                    st_o.a  = 4'h0;
                  end
                  OP_A10AAC: begin
                    sum = {1'b0, a} + 5'd10;
                    st_o.a = sum[3:0];
                    s = sum[4];
                  end
                  OP_A6AAC: begin
                    sum = {1'b0, a} + 5'd6;
                    st_o.a = sum[3:0];
                    s = sum[4];
                  end
                  OP_DAN: begin
                    s = (a != 4'h0);
                    st_o.a = a - 4'h1;
                  end
                  OP_TKA: st_o.a = key_pins_i;
                  OP_KNEZ: s = (key_pins_i != 4'h0);
                  OP_TDO: st_o.o = st_i.s ? seg7(a) : {3'b000, a};
                  OP_CLO: st_o.o = 7'h00;
                  OP_RSTR: st_o.r = st_i.r & ~(16'h0001 << y);
                  OP_SETR: st_o.r = st_i.r | (16'h0001 << y);
                  OP_IA: st_o.a = a + 4'h1;
                  OP_RETN: begin
                    if (st_i.cl) begin
                      st_o.pc = st_i.ret;
                      st_o.cl = 1'b0;
                    end
                    st_o.page = st_i.pbuf;
                  end
                  OP_TAMIY: begin
                    wr_o.we = 1'b1;
                    st_o.y  = y + 4'h1;
                  end
                  OP_TMA: st_o.a = m;
                  OP_TMY: st_o.y = m;
                  OP_TYA: st_o.a = y;
                  OP_TAY: st_o.y = a;
                  OP_AMAAC: begin
                    sum = {1'b0, m} + {1'b0, a};
                    st_o.a = sum[3:0];
                    s = sum[4];
                  end
                  OP_MNEZ: s = (m != 4'h0);
                  OP_SAMAN: begin
                    s = (a <= m);
                    st_o.a = m - a;
                  end
                  OP_IMAC: begin
                    sum = {1'b0, m} + 5'd1;
                    st_o.a = sum[3:0];
                    s = sum[4];
                  end
                  OP_ALEM: s = (a <= m);
                  OP_DMAN: begin
                    st_o.a = m - 4'h1;
                    s = (m != 4'h0);
                  end
                  OP_IYC: begin
                    sum = {1'b0, y} + 5'd1;
                    st_o.y = sum[3:0];
                    s = sum[4];
                  end
                  OP_DYN: begin
                    s = (y != 4'h0);
                    st_o.y = y - 4'h1;
                  end
                  OP_CPAIZ: begin
                    st_o.a = 4'h0 - a;
                    s = (a == 4'h0);
                  end
                  OP_XMA: begin
                    wr_o.we = 1'b1;
                    st_o.a  = m;
                  end
                  OP_CLA: st_o.a = 4'h0;
                  default: illegal_o = 1'b1;
                endcase
              end
            endcase
          end
        endcase
      end
    endcase

    st_o.s = s;
  end

endmodule

`default_nettype wire

FILE: src/four_bit_microcontroller_core.sv
// Top level of the four-bit microcontroller core: registers, RAM, result buffer.
// Depends on fbmc_pkg, fbmc_if, fbmc_ram and fbmc_exec.
`default_nettype none

// Executes one instruction per accepted input word, one word per clock when
// both sides keep up. The result word (next fetch address, O and R latches,
// status, accumulator, illegal flag) is written into the output buffer when
// the input word is taken. All architectural registers live in flops; the
// 64-nibble data RAM is a synchronous memory whose read address tracks the
// next X/Y value, so the nibble at the current X*16+Y is already registered
// when the next word arrives; a write to that same entry is bypassed into the
// read register. Each RAM entry has a valid bit cleared at reset, so no
// clearing pass is needed and a never-written nibble reads as zero. A
// two-word output buffer lets the core keep taking input while a result
// waits; input ready drops only when both buffer words are occupied.
module four_bit_microcontroller_core import fbmc_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  fbmc_in_if.sink     in_i,
  fbmc_out_if.source  out_o
);

  fbmc_state_t  st_q;
  fbmc_state_t  st_d;
  fbmc_state_t  st_next;
  fbmc_ram_wr_t wr_exec;
  fbmc_ram_wr_t wr_ram;
  logic [3:0]   mem_rd;
  logic         illegal;
  logic         accept;

  fbmc_res_t    res_d;
  fbmc_res_t    buf_q [2];
  logic         wr_ptr_q;
  logic         rd_ptr_q;
  logic [1:0]   count_q;
  logic         pop;

  assign accept = in_i.valid && in_i.ready;

  // decode/execute against the current registers and the RAM nibble at X/Y
  fbmc_exec u_exec (
    .st_i       (st_q),
    .opcode_i   (in_i.opcode),
    .key_pins_i (in_i.key_pins),
    .mem_i      (mem_rd),
    .st_o       (st_next),
    .wr_o       (wr_exec),
    .illegal_o  (illegal)
  );

  always_comb begin
    st_d      = accept ? st_next : st_q;
    wr_ram    = wr_exec;
    wr_ram.we = wr_exec.we && accept;
  end

  // read address follows the X/Y the next word will see
  fbmc_ram u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr_ram),
    .rd_addr_i ({st_d.x, st_d.y}),
    .rd_data_o (mem_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StateReset;
    end else begin
      st_q <= st_d;
    end
  end

  // result word built from the post-instruction registers
  always_comb begin
    res_d.fetch_address  = {st_next.page, st_next.pc};
    res_d.o_outputs      = st_next.o;
    res_d.r_outputs      = st_next.r;
    res_d.status_out     = st_next.s;
    res_d.illegal_opcode = illegal;
    res_d.acc_out        = st_next.a;
  end

  // two-word output buffer
  assign pop = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      buf_q[wr_ptr_q] <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (accept) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      case ({accept, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  assign in_i.ready  = (count_q != 2'd2);
  assign out_o.valid = (count_q != 2'd0);

  always_comb begin
    out_o.fetch_address  = buf_q[rd_ptr_q].fetch_address;
    out_o.o_outputs      = buf_q[rd_ptr_q].o_outputs;
    out_o.r_outputs      = buf_q[rd_ptr_q].r_outputs;
    out_o.status_out     = buf_q[rd_ptr_q].status_out;
    out_o.illegal_opcode = buf_q[rd_ptr_q].illegal_opcode;
    out_o.acc_out        = buf_q[rd_ptr_q].acc_out;
  end

endmodule

`default_nettype wire

FILE: src/fbmc_checker.sv
// Port-level checker for the four-bit core, bound onto the top level.
// Depends on four_bit_microcontroller_core_assert.svh.
`default_nettype none

`include "four_bit_microcontroller_core_assert.svh"

module fbmc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic       out_illegal_i,
  input wire logic [9:0] out_fetch_i
);

  // every opcode decodes, so the flag never shows
  `FBMC_ASSERT_NOW(a_no_illegal, clk_i, rst_ni, out_valid_i, !out_illegal_i, "illegal flag set")

  // a taken word yields a result word on the next cycle
  `FBMC_ASSERT_NEXT(a_result_next, clk_i, rst_ni, in_valid_i && in_ready_i, out_valid_i, "no result after accept")

  // input backpressure only when results are pending
  `FBMC_ASSERT_NOW(a_stall_pending, clk_i, rst_ni, !in_ready_i, out_valid_i, "stall with empty output")

  `FBMC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_fetch_i), "stalled result changed")

endmodule

bind four_bit_microcontroller_core fbmc_checker u_fbmc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_illegal_i (out_o.illegal_opcode),
  .out_fetch_i   (out_o.fetch_address)
);

`default_nettype wire

FILE: dv/fbmc_exec_checker.sv
`timescale 1ns / 100ps
// Result checker for the four-bit core: watches the instruction and result channels.
// Depends on fbmc_pkg and fbmc_if; predicts each result word and compares it.
module fbmc_exec_checker import fbmc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  fbmc_in_if   instr_i,
  fbmc_out_if  result_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   checked_o
);

  // 7-segment patterns, digit 0 in the low bits
  localparam logic [16*7-1:0] DigitSegments = {
    7'h47, 7'h4f, 7'h3d, 7'h4e, 7'h1f, 7'h77, 7'h7b, 7'h7f,
    7'h70, 7'h5f, 7'h5b, 7'h33, 7'h79, 7'h6d, 7'h30, 7'h7e
  };

  // Architectural state of the core as predicted
  logic [5:0]  prog_counter;
  logic [3:0]  page_reg;
  logic [3:0]  page_buf;
  logic        call_latched;
  logic [5:0]  return_pc;
  logic        status;
  logic [3:0]  acc;
  logic [1:0]  x_reg;
  logic [3:0]  y_reg;
  logic [3:0]  data_ram [64];
  logic [6:0]  o_latch;
  logic [15:0] r_latch;

  fbmc_res_t   expected_results [$];
  fbmc_res_t   want;

  function automatic logic [5:0] lfsr_advance(input logic [5:0] cur);
    logic feed;
    case (cur)
      6'h1f:   feed = 1'b1;
      6'h3f:   feed = 1'b0;
      default: feed = ~(cur[5] ^ cur[4]);
    endcase
    return {cur[4:0], feed};
  endfunction

  // Runs one instruction on the predicted state, returns the result word
  function automatic fbmc_res_t execute_word(input logic [7:0] op, input logic [3:0] keys);
    logic [5:0] xy;
    logic [3:0] m;
    logic [3:0] c4;
    logic [3:0] bit_mask;
    logic [3:0] old_page;
    logic [4:0] sum;
    logic       prev_s;
    logic       s_next;
    logic       undefined;
    fbmc_res_t  res;
    xy        = {x_reg, y_reg};
    m         = data_ram[xy];
    c4        = {op[0], op[1], op[2], op[3]};
    bit_mask  = 4'b0001 << {op[0], op[1]};
    prev_s    = status;
    s_next    = 1'b1;
    undefined = 1'b0;
    sum       = '0;

    // counter steps before the instruction; jumps overwrite it
    prog_counter = lfsr_advance(prog_counter);

    if (op[7:6] == GrpBr) begin
      if (prev_s) begin
        if (!call_latched) page_reg = page_buf;
        prog_counter = op[5:0];
      end
    end else if (op[7:6] == GrpCall) begin
      if (prev_s) begin
        if (!call_latched) begin
          old_page     = page_reg;
          return_pc    = prog_counter;
          page_reg     = page_buf;
          page_buf     = old_page;
          call_latched = 1'b1;
        end else begin
          page_reg = page_buf;
        end
        prog_counter = op[5:0];
      end
    end else if (op[7:4] == GrpLdp) begin
      page_buf = c4;
    end else if (op[7:4] == GrpTcy) begin
      y_reg = c4;
    end else if (op[7:4] == GrpYnec) begin
      s_next = (m != c4);
    end else if (op[7:4] == GrpTcmiy) begin
      data_ram[xy] = c4;
      y_reg = y_reg + 4'd1;
    end else if (op[7:4] == GrpAlec) begin
      s_next = (acc <= c4);
    end else if (op[7:2] == GrpSbit) begin
      data_ram[xy] = m | bit_mask;
    end else if (op[7:2] == GrpRbit) begin
      data_ram[xy] = m & ~bit_mask;
    end else if (op[7:2] == GrpTbit) begin
      s_next = |(m & bit_mask);
    end else if (op[7:2] == GrpLdx) begin
      x_reg = {op[0], op[1]};
    end else begin
      case (op)
        OP_COMX:   x_reg = ~x_reg;
        OP_A8AAC: begin
          sum = {1'b0, acc} + 5'd8;
          acc = sum[3:0];
          s_next = sum[4];
        end
        OP_YNEA:   s_next = (y_reg != acc);
        OP_TAM:    data_ram[xy] = acc;
        OP_TAMZA: begin
          data_ram[xy] = acc;
          acc = 4'd0;
        end
        OP_A10AAC: begin
          sum = {1'b0, acc} + 5'd10;
          acc = sum[3:0];
          s_next = sum[4];
        end
        OP_A6AAC: begin
          sum = {1'b0, acc} + 5'd6;
          acc = sum[3:0];
          s_next = sum[4];
        end
        OP_DAN: begin
          s_next = (acc != 4'd0);
          acc = acc - 4'd1;
        end
        OP_TKA:    acc = keys;
        OP_KNEZ:   s_next = (keys != 4'd0);
        OP_TDO:    o_latch = prev_s ? DigitSegments[acc*7 +: 7] : {3'b000, acc};
        OP_CLO:    o_latch = 7'd0;
        OP_RSTR:   r_latch = r_latch & ~(16'h0001 << y_reg);
        OP_SETR:   r_latch = r_latch | (16'h0001 << y_reg);
        OP_IA:     acc = acc + 4'd1;
        OP_RETN: begin
          if (call_latched) begin
            prog_counter = return_pc;
            call_latched = 1'b0;
          end
          page_reg = page_buf;
        end
        OP_TAMIY: begin
          data_ram[xy] = acc;
          y_reg = y_reg + 4'd1;
        end
        OP_TMA:    acc = m;
        OP_TMY:    y_reg = m;
        OP_TYA:    acc = y_reg;
        OP_TAY:    y_reg = acc;
        OP_AMAAC: begin
          sum = {1'b0, m} + {1'b0, acc};
          acc = sum[3:0];
          s_next = sum[4];
        end
        OP_MNEZ:   s_next = (m != 4'd0);
        OP_SAMAN: begin
          s_next = (acc <= m);
          acc = m - acc;
        end
        OP_IMAC: begin
          sum = {1'b0, m} + 5'd1;
          acc = sum[3:0];
          s_next = sum[4];
        end
        OP_ALEM:   s_next = (acc <= m);
        OP_DMAN: begin
          acc = m - 4'd1;
          s_next = (m != 4'd0);
        end
        OP_IYC: begin
          sum = {1'b0, y_reg} + 5'd1;
          y_reg = sum[3:0];
          s_next = sum[4];
        end
        OP_DYN: begin
          s_next = (y_reg != 4'd0);
          y_reg = y_reg - 4'd1;
        end
        OP_CPAIZ: begin
          acc = 4'd0 - acc;
          s_next = (acc == 4'd0);
        end
        OP_XMA: begin
          data_ram[xy] = acc;
          acc = m;
        end
        OP_CLA:    acc = 4'd0;
        default:   undefined = 1'b1;
      endcase
    end

    status = s_next;
    res.fetch_address  = {page_reg, prog_counter};
    res.o_outputs      = o_latch;
    res.r_outputs      = r_latch;
    res.status_out     = status;
    res.illegal_opcode = undefined;
    res.acc_out        = acc;
    return res;
  endfunction

  task automatic check_field(input string field, input logic [15:0] exp_val,
                             input logic [15:0] got_val);
    if (got_val !== exp_val) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, field, exp_val, got_val);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_counter = 6'h00;
      page_reg     = 4'hf;
      page_buf     = 4'hf;
      call_latched = 1'b0;
      return_pc    = 6'h00;
      status       = 1'b0;
      acc          = 4'h0;
      x_reg        = 2'h0;
      y_reg        = 4'h0;
      o_latch      = 7'h00;
      r_latch      = 16'h0000;
      for (int i = 0; i < 64; i++) data_ram[i] = 4'h0;
      expected_results.delete();
      fail_count_o = 0;
      checked_o    = 0;
      pending_o    = 0;
    end else begin
      // predict first so a result leaving in the same cycle would still find its word
      if (instr_i.valid && instr_i.ready)
        expected_results.push_back(execute_word(instr_i.opcode, instr_i.key_pins));
      if (result_i.valid && result_i.ready) begin
        checked_o++;
        if (expected_results.size() == 0) begin
          $display("%0t: result word with none expected, fetch_address 0x%0h",
                   $time, result_i.fetch_address);
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          check_field("fetch_address", want.fetch_address, result_i.fetch_address);
          check_field("o_outputs", want.o_outputs, result_i.o_outputs);
          check_field("r_outputs", want.r_outputs, result_i.r_outputs);
          check_field("status_out", want.status_out, result_i.status_out);
          check_field("illegal_opcode", want.illegal_opcode, result_i.illegal_opcode);
          check_field("acc_out", want.acc_out, result_i.acc_out);
        end
      end
      pending_o = expected_results.size();
    end
  end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// Top of the four-bit core testbench: clock, reset, instruction stimulus, verdict.
// Depends on fbmc_pkg, fbmc_if, the core and fbmc_exec_checker.
module tb_top import fbmc_pkg::*;;

  localparam int BusyWords   = 1650;    // random words sent with idling on both sides
  localparam int TotalWords  = 1900;    // the rest go out with no idling at all
  localparam int DrainCycles = 10;      // core has a registered result plus a 2-word buffer
  localparam int CycleLimit  = 400_000; // hard stop for a run that hangs

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  fbmc_in_if  instr_if ();
  fbmc_out_if result_if ();

  int fail_count;
  int pending_words;
  int results_checked;

  int words_sent     = 0;
  int directed_words = 0;
  int gap_pct        = 20;   // chance (percent) of an idle burst before a word
  bit steady_flow    = 1'b0; // set for the closing stretch: no idling anywhere
  int unsigned clk_ticks = 0;

  always #6 clk_i = ~clk_i;

  four_bit_microcontroller_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (instr_if),
    .out_o  (result_if)
  );

  fbmc_exec_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .instr_i      (instr_if),
    .result_i     (result_if),
    .fail_count_o (fail_count),
    .pending_o    (pending_words),
    .checked_o    (results_checked)
  );

  // Hard stop; a result that never shows up ends up here.
  always @(posedge clk_i) begin
    clk_ticks <= clk_ticks + 1;
    if (clk_ticks >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d result words outstanding",
               clk_ticks, pending_words);
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side back-pressure: ready-high stretches of random length, now and
  // then a stall burst. Stalls stop once steady_flow is set.
  initial begin
    result_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      result_if.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      if (!steady_flow && $urandom_range(0, 2) == 0) begin
        result_if.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
    end
  end

  // Offer one instruction word, optionally after an idle burst, and hold it
  // until the core takes it. Valid stays high from word to word unless a gap
  // is inserted, so it never gets two assignments in one time step.
  task automatic push_instruction(input logic [7:0] op, input logic [3:0] keys);
    if (!steady_flow && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      instr_if.valid  <= 1'b0;
      instr_if.opcode <= 8'($urandom_range(0, 255)); // junk while idle
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    instr_if.valid    <= 1'b1;
    instr_if.opcode   <= op;
    instr_if.key_pins <= keys;
    do @(posedge clk_i); while (!instr_if.ready);
    words_sent++;
  endtask

  // Drop valid and hold off until every predicted result word has come back.
  task automatic settle();
    instr_if.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending_words == 0);
    @(posedge clk_i);
  endtask

  // Non-jump op for subroutine bodies; sometimes a nested call, which the
  // core treats as a plain jump while a call is already latched.
  function automatic logic [7:0] pick_body_op();
    logic [5:0] target;
    target = 6'($urandom_range(0, 63));
    if ($urandom_range(0, 9) == 0) return {GrpCall, target};
    return 8'($urandom_range(0, 127));
  endfunction

  // Random programs. Jumps only go through with status 1, and a return only
  // does real work after a call, so most of the stream is built from short
  // well-formed pieces:
  //   - subroutine: load a page into the buffer (leaves status 1), call,
  //     a random body, return
  //   - test then branch: any status-producing op followed by a branch
  //   - the rest is fully random opcodes
  task automatic run_program_stream(input int upto);
    int         kind;
    logic [3:0] nib;
    logic [5:0] target;
    while (words_sent < upto) begin
      kind   = $urandom_range(0, 99);
      nib    = 4'($urandom_range(0, 15));
      target = 6'($urandom_range(0, 63));
      if (kind < 25) begin
        push_instruction({GrpLdp, nib}, 4'($urandom_range(0, 15)));
        push_instruction({GrpCall, target}, 4'($urandom_range(0, 15)));
        repeat ($urandom_range(1, 6))
          push_instruction(pick_body_op(), 4'($urandom_range(0, 15)));
        push_instruction(OP_RETN, 4'($urandom_range(0, 15)));
      end else if (kind < 50) begin
        push_instruction(8'($urandom_range(0, 127)), 4'($urandom_range(0, 15)));
        push_instruction({GrpBr, target}, 4'($urandom_range(0, 15)));
      end else begin
        push_instruction(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
      end
    end
  endtask

  initial begin
    instr_if.valid    <= 1'b0;
    instr_if.opcode   <= 8'h00;
    instr_if.key_pins <= 4'h0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening. Status is 0 out of reset, which the first digit
    // output uses; the comments track status and key registers as they go.
    push_instruction(OP_TDO, 4'h0);    // digit output, status 0: raw acc to O
    push_instruction(8'h9f, 4'h0);     // branch taken to counter 0x1f
    push_instruction(OP_CLA, 4'h0);    // counter wraps 0x1f -> 0x3f
    push_instruction(OP_IA, 4'h0);     // counter wraps 0x3f -> 0x3e
    push_instruction(OP_TKA, 4'hf);    // acc = 15, all key pins high
    push_instruction(OP_A8AAC, 4'h0);  // add with carry out
    push_instruction(OP_KNEZ, 4'h0);   // keys all low: status 0
    push_instruction(8'hbf, 4'h0);     // branch not taken
    push_instruction(OP_TKA, 4'h9);
    push_instruction(OP_TDO, 4'h0);    // digit output, status 1: segment pattern
    push_instruction(8'h1a, 4'h0);     // page buffer = bit-reversed 0xa
    push_instruction(8'hc7, 4'h0);     // call, saves return address
    push_instruction(8'hc3, 4'h0);     // call while latched: jump only
    push_instruction(OP_RETN, 4'h0);   // return
    push_instruction(OP_RETN, 4'h0);   // return without a call pending
    push_instruction(8'h3f, 4'h0);     // X = 3
    push_instruction(8'h4f, 4'h0);     // Y = 15
    push_instruction(OP_SETR, 4'h0);   // top R line
    push_instruction(8'h6f, 4'h0);     // store constant, Y wraps to 0
    push_instruction(OP_DYN, 4'h0);    // decrement Y from 0
    push_instruction(OP_TMA, 4'h0);
    push_instruction(OP_AMAAC, 4'h0);  // 15 + 15, carry out
    push_instruction(OP_RSTR, 4'h0);
    push_instruction(8'h30, 4'h0);     // set bit
    push_instruction(8'h3b, 4'h0);     // test bit
    push_instruction(8'h37, 4'h0);     // clear bit
    push_instruction(8'h70, 4'h0);     // acc <= constant 0 fails
    push_instruction(OP_CPAIZ, 4'h0);
    push_instruction(OP_COMX, 4'h0);   // lowest opcode
    push_instruction(8'hff, 4'h0);     // highest opcode: call to 0x3f
    directed_words = words_sent;
    settle();

    // Random part in chunks, each with its own idle density; at random
    // chunk boundaries the sender waits for the core to drain.
    while (words_sent < BusyWords) begin
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 15;
        default: gap_pct = 40;
      endcase
      run_program_stream(words_sent + 150);
      if ($urandom_range(0, 2) == 0) settle();
    end

    // Closing stretch at full rate on both sides
    steady_flow = 1'b1;
    run_program_stream(TotalWords);

    settle();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d instruction words (%0d directed, rest random programs with",
             words_sent, directed_words);
    $display("calls, returns, branches and data ops); checked %0d result words",
             results_checked);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/fbmc_pkg.sv
src/fbmc_if.sv
src/fbmc_ram.sv
src/fbmc_exec.sv
src/four_bit_microcontroller_core.sv
src/fbmc_checker.sv
dv/fbmc_exec_checker.sv
dv/tb_top.sv
